// ----- hdl/rate_monotonic_scheduler_macros.svh -----
// Assertion macros shared by the checker.
`ifndef RATE_MONOTONIC_SCHEDULER_MACROS_SVH
`define RATE_MONOTONIC_SCHEDULER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RMS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rate monotonic scheduler check failed");

// The consequent must hold in the cycle after the antecedent.
`define RMS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rate monotonic scheduler check failed");

`endif

// ----- hdl/rms_pkg.sv -----
package rms_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int TIME_BITS   = 32;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [2:0] EV_ACCEPTED = 3'd0;
  localparam logic [2:0] EV_REJECTED = 3'd1;
  localparam logic [2:0] EV_MISSED   = 3'd2;
  localparam logic [2:0] EV_PREEMPT  = 3'd3;
  localparam logic [2:0] EV_STARTED  = 3'd4;
  localparam logic [2:0] EV_FINISHED = 3'd5;
  localparam logic [2:0] EV_TICK_END = 3'd6;

  localparam logic OP_ARRIVAL = 1'b0;

  typedef enum logic [2:0] {
    SRC_IN   = 3'd0,
    SRC_RUN  = 3'd1,
    SRC_HEAD = 3'd2,
    SRC_FIN  = 3'd3,
    SRC_ZERO = 3'd4
  } src_t;

  typedef struct packed {
    logic       load_in;
    logic       emit;
    logic [2:0] ev;
    src_t       src;
    logic       busy;
    logic       last;
    logic       insert_in;
    logic       insert_sav;
    logic       drop_head;
    logic       start_head;
    logic       kill_run;
    logic       save_run;
    logic       charge;
    logic       time_inc;
  } cmd_t;

  typedef struct packed {
    logic slot_free;
    logic run_valid;
    logic q_nonempty;
    logic q_full;
    logic run_exp;
    logic head_exp;
    logic head_wins;
    logic charge_fin;
  } sts_t;

  function automatic logic [15:0] left_of(input logic [15:0] ex, input logic [15:0] dn);
    left_of = (dn >= ex) ? 16'd0 : 16'(ex - dn);
  endfunction

endpackage

// ----- hdl/rate_monotonic_scheduler.sv -----
// An accepted arrival yields a single result word, emitted from S_ARR.
// A tick walks S_KRUN, S_KQ (once more per expired queued job), S_SCHED, S_CHARGE, S_TEND,
// with S_PST and S_REINS after S_SCHED on a preemption. The tick sequencer walks one step
// per cycle and stalls while the output register is full. The block takes no new item until
// it is through with the last one, and takes the next once that item's last word is registered.
// Reset (synchronous, active low) empties the ready queue, idles the processor and zeroes time.
module rate_monotonic_scheduler
  import rms_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // task_id, exec_time, period
  input  logic        in_tuser,   // opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // event_res, job_task, event_time, remaining, cpu_busy
  output logic        out_tlast
);

  cmd_t cmd;
  sts_t sts;

  rms_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_opcode (in_tuser),
    .sts       (sts),
    .cmd       (cmd)
  );

  rms_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ----- hdl/rms_ctrl.sv -----
module rms_ctrl
  import rms_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  logic in_opcode,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_ARR    = 9'b000000010,
    S_KRUN   = 9'b000000100,
    S_KQ     = 9'b000001000,
    S_SCHED  = 9'b000010000,
    S_PST    = 9'b000100000,
    S_REINS  = 9'b001000000,
    S_CHARGE = 9'b010000000,
    S_TEND   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    cmd.src = SRC_IN;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt = (in_opcode == OP_ARRIVAL) ? S_ARR : S_KRUN;
        end
      end
      S_ARR: begin
        if (sts.slot_free) begin
          cmd.emit = 1'b1;
          cmd.ev = sts.q_full ? EV_REJECTED : EV_ACCEPTED;
          cmd.src = SRC_IN;
          cmd.busy = sts.run_valid;
          cmd.last = 1'b1;
          cmd.insert_in = !sts.q_full;
          state_nxt = S_IDLE;
        end
      end
      S_KRUN: begin
        if (sts.slot_free) begin
          if (sts.run_valid && sts.run_exp) begin
            cmd.emit = 1'b1;
            cmd.ev = EV_MISSED;
            cmd.src = SRC_RUN;
            cmd.kill_run = 1'b1;
          end
          state_nxt = S_KQ;
        end
      end
      S_KQ: begin
        if (sts.slot_free) begin
          if (sts.q_nonempty && sts.head_exp) begin
            cmd.emit = 1'b1;
            cmd.ev = EV_MISSED;
            cmd.src = SRC_HEAD;
            cmd.busy = sts.run_valid;
            cmd.drop_head = 1'b1;
          end else begin
            state_nxt = S_SCHED;
          end
        end
      end
      S_SCHED: begin
        if (sts.slot_free) begin
          state_nxt = S_CHARGE;
          if (sts.q_nonempty && !sts.run_valid) begin
            cmd.emit = 1'b1;
            cmd.ev = EV_STARTED;
            cmd.src = SRC_HEAD;
            cmd.busy = 1'b1;
            cmd.start_head = 1'b1;
            cmd.drop_head = 1'b1;
          end else if (sts.q_nonempty && sts.head_wins) begin
            cmd.emit = 1'b1;
            cmd.ev = EV_PREEMPT;
            cmd.src = SRC_RUN;
            cmd.busy = 1'b1;
            cmd.save_run = 1'b1;
            state_nxt = S_PST;
          end
        end
      end
      S_PST: begin
        if (sts.slot_free) begin
          cmd.emit = 1'b1;
          cmd.ev = EV_STARTED;
          cmd.src = SRC_HEAD;
          cmd.busy = 1'b1;
          cmd.start_head = 1'b1;
          cmd.drop_head = 1'b1;
          state_nxt = S_REINS;
        end
      end
      S_REINS: begin
        cmd.insert_sav = 1'b1;
        state_nxt = S_CHARGE;
      end
      S_CHARGE: begin
        if (sts.slot_free) begin
          if (sts.run_valid) begin
            cmd.charge = 1'b1;
            if (sts.charge_fin) begin
              cmd.emit = 1'b1;
              cmd.ev = EV_FINISHED;
              cmd.src = SRC_FIN;
              cmd.kill_run = 1'b1;
            end
          end
          state_nxt = S_TEND;
        end
      end
      S_TEND: begin
        if (sts.slot_free) begin
          cmd.emit = 1'b1;
          cmd.ev = EV_TICK_END;
          cmd.src = sts.run_valid ? SRC_RUN : SRC_ZERO;
          cmd.busy = sts.run_valid;
          cmd.last = 1'b1;
          cmd.time_inc = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- hdl/rms_dpath.sv -----
module rms_dpath
  import rms_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [39:0] in_tdata,
  input  cmd_t        cmd,
  output sts_t        sts,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,
  output logic        out_tlast
);

  logic [7:0]           in_task_r;
  logic [15:0]          in_exec_r, in_per_r;
  logic [7:0]           q_task_r [QUEUE_DEPTH];
  logic [15:0]          q_exec_r [QUEUE_DEPTH];
  logic [15:0]          q_per_r  [QUEUE_DEPTH];
  logic [TIME_BITS-1:0] q_arr_r  [QUEUE_DEPTH];
  logic [15:0]          q_done_r [QUEUE_DEPTH];
  logic [CNT_W-1:0]     q_count_r;
  logic                 run_valid_r;
  logic [7:0]           run_task_r, sav_task_r;
  logic [15:0]          run_exec_r, run_per_r, run_done_r;
  logic [15:0]          sav_exec_r, sav_per_r, sav_done_r;
  logic [TIME_BITS-1:0] run_arr_r, sav_arr_r, time_r;
  logic                 out_valid_r, out_last_r;
  logic [63:0]          out_data_r;

  logic [7:0]           ins_task;
  logic [15:0]          ins_exec, ins_per, ins_done, done_inc;
  logic [TIME_BITS-1:0] ins_arr;
  logic [QUEUE_DEPTH-1:0] ahead;
  logic [7:0]           ev_task;
  logic [15:0]          ev_rem;

  assign ins_task = cmd.insert_sav ? sav_task_r : in_task_r;
  assign ins_exec = cmd.insert_sav ? sav_exec_r : in_exec_r;
  assign ins_per  = cmd.insert_sav ? sav_per_r  : in_per_r;
  assign ins_arr  = cmd.insert_sav ? sav_arr_r  : time_r;
  assign ins_done = cmd.insert_sav ? sav_done_r : 16'd0;

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      ahead[i] = (CNT_W'(i) < q_count_r) &&
                 ((q_per_r[i] < ins_per) ||
                  ((q_per_r[i] == ins_per) && (q_arr_r[i] <= ins_arr)));
    end
  end

  assign done_inc = (run_done_r == 16'hFFFF) ? run_done_r : 16'(run_done_r + 16'd1);

  assign sts.slot_free  = !out_valid_r || out_tready;
  assign sts.run_valid  = run_valid_r;
  assign sts.q_nonempty = (q_count_r != '0);
  assign sts.q_full     = (q_count_r >= CNT_W'(QUEUE_DEPTH));
  assign sts.run_exp    = ({1'b0, time_r} >= ({1'b0, run_arr_r} + (TIME_BITS + 1)'(run_per_r)));
  assign sts.head_exp   = ({1'b0, time_r} >= ({1'b0, q_arr_r[0]} + (TIME_BITS + 1)'(q_per_r[0])));
  assign sts.head_wins  = (q_per_r[0] < run_per_r) ||
                          ((q_per_r[0] == run_per_r) && (q_arr_r[0] < run_arr_r));
  assign sts.charge_fin = (done_inc >= run_exec_r);

  always_comb begin
    case (cmd.src)
      SRC_IN: begin
        ev_task = in_task_r;
        ev_rem  = in_exec_r;
      end
      SRC_RUN: begin
        ev_task = run_task_r;
        ev_rem  = left_of(run_exec_r, run_done_r);
      end
      SRC_HEAD: begin
        ev_task = q_task_r[0];
        ev_rem  = left_of(q_exec_r[0], q_done_r[0]);
      end
      SRC_FIN: begin
        ev_task = run_task_r;
        ev_rem  = 16'd0;
      end
      default: begin
        ev_task = 8'd0;
        ev_rem  = 16'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_task_r <= in_tdata[7:0];
      in_exec_r <= in_tdata[23:8];
      in_per_r  <= in_tdata[39:24];
    end
    if (cmd.save_run) begin
      sav_task_r <= run_task_r;
      sav_exec_r <= run_exec_r;
      sav_per_r  <= run_per_r;
      sav_arr_r  <= run_arr_r;
      sav_done_r <= run_done_r;
    end
    if (cmd.emit) begin
      out_data_r <= {4'd0, cmd.busy, ev_rem, 32'(time_r), ev_task, cmd.ev};
      out_last_r <= cmd.last;
    end
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (cmd.drop_head) begin
        if (i < QUEUE_DEPTH - 1) begin
          q_task_r[i] <= q_task_r[i+1];
          q_exec_r[i] <= q_exec_r[i+1];
          q_per_r[i]  <= q_per_r[i+1];
          q_arr_r[i]  <= q_arr_r[i+1];
          q_done_r[i] <= q_done_r[i+1];
        end
      end else if (cmd.insert_in || cmd.insert_sav) begin
        if (!ahead[i] && (i == 0 || ahead[(i == 0) ? 0 : i-1])) begin
          q_task_r[i] <= ins_task;
          q_exec_r[i] <= ins_exec;
          q_per_r[i]  <= ins_per;
          q_arr_r[i]  <= ins_arr;
          q_done_r[i] <= ins_done;
        end else if (!ahead[i] && i > 0) begin
          q_task_r[i] <= q_task_r[(i == 0) ? 0 : i-1];
          q_exec_r[i] <= q_exec_r[(i == 0) ? 0 : i-1];
          q_per_r[i]  <= q_per_r[(i == 0) ? 0 : i-1];
          q_arr_r[i]  <= q_arr_r[(i == 0) ? 0 : i-1];
          q_done_r[i] <= q_done_r[(i == 0) ? 0 : i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_count_r   <= '0;
      run_valid_r <= 1'b0;
      run_task_r  <= '0;
      run_exec_r  <= '0;
      run_per_r   <= '0;
      run_arr_r   <= '0;
      run_done_r  <= '0;
      time_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.drop_head) begin
        q_count_r <= q_count_r - CNT_W'(1);
      end else if (cmd.insert_in || cmd.insert_sav) begin
        q_count_r <= q_count_r + CNT_W'(1);
      end
      if (cmd.start_head) begin
        run_valid_r <= 1'b1;
        run_task_r  <= q_task_r[0];
        run_exec_r  <= q_exec_r[0];
        run_per_r   <= q_per_r[0];
        run_arr_r   <= q_arr_r[0];
        run_done_r  <= q_done_r[0];
      end else begin
        if (cmd.kill_run) begin
          run_valid_r <= 1'b0;
        end
        if (cmd.charge) begin
          run_done_r <= done_inc;
        end
      end
      if (cmd.time_inc && (time_r != '1)) begin
        time_r <= time_r + TIME_BITS'(1);
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

// ----- hdl/rms_checker.sv -----
`include "rate_monotonic_scheduler_macros.svh"

module rms_checker
  import rms_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic        out_tlast
);

  `RMS_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid)
  `RMS_ASSERT_NOW(a_code_range, out_tvalid, out_tdata[2:0] != 3'd7)
  `RMS_ASSERT_NOW(a_tick_end_last, out_tvalid && (out_tdata[2:0] == EV_TICK_END), out_tlast)
  `RMS_ASSERT_NXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready)

endmodule

bind rate_monotonic_scheduler rms_checker u_rms_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

// ----- verif/rate_monotonic_scheduler_tb.sv -----
`timescale 1ns / 1ps

module rate_monotonic_scheduler_tb;
  import rms_pkg::*;

  localparam logic OP_TICK = ~OP_ARRIVAL;

  typedef struct {
    logic [2:0]  ev;
    logic [7:0]  tid;
    logic [31:0] at;
    logic [15:0] rem;
    logic        busy;
    logic        last;
  } sched_event_t;

  typedef struct {
    logic [7:0]  tid;
    logic [15:0] ex;
    logic [15:0] per;
    logic [31:0] arr;
    logic [15:0] done;
  } job_t;

  class sched_scoreboard;
    job_t         ready_q[$];
    job_t         running;
    logic         run_valid;
    logic [31:0]  now;
    sched_event_t events_due[$];
    int           checked;

    function new();
      run_valid = 1'b0;
      now = '0;
      checked = 0;
    endfunction

    function logic [15:0] units_left(input logic [15:0] ex, input logic [15:0] dn);
      return (dn >= ex) ? 16'd0 : 16'(ex - dn);
    endfunction

    function bit is_expired(input logic [31:0] arr, input logic [15:0] per);
      return {1'b0, now} >= ({1'b0, arr} + 33'(per));
    endfunction

    function void push_event(input logic [2:0] ev, input logic [7:0] tid,
                             input logic [15:0] rem);
      sched_event_t e;
      e.ev = ev;
      e.tid = tid;
      e.at = now;
      e.rem = rem;
      e.busy = run_valid;
      e.last = 1'b0;
      events_due.push_back(e);
    endfunction

    function void enqueue(input job_t j);
      int pos;
      pos = 0;
      while (pos < ready_q.size() && (ready_q[pos].per < j.per ||
             (ready_q[pos].per == j.per && ready_q[pos].arr <= j.arr)))
        pos++;
      ready_q.insert(pos, j);
    endfunction

    function void start_head();
      running = ready_q[0];
      run_valid = 1'b1;
      ready_q.delete(0);
      push_event(EV_STARTED, running.tid, units_left(running.ex, running.done));
    endfunction

    function void note_item(input logic op, input logic [7:0] tid,
                            input logic [15:0] ex, input logic [15:0] per);
      job_t j;
      job_t saved;
      if (op == OP_ARRIVAL) begin
        if (ready_q.size() >= QUEUE_DEPTH) begin
          push_event(EV_REJECTED, tid, ex);
        end else begin
          j.tid = tid;
          j.ex = ex;
          j.per = per;
          j.arr = now;
          j.done = '0;
          enqueue(j);
          push_event(EV_ACCEPTED, tid, ex);
        end
      end else begin
        if (run_valid && is_expired(running.arr, running.per)) begin
          run_valid = 1'b0;
          push_event(EV_MISSED, running.tid, units_left(running.ex, running.done));
        end
        while (ready_q.size() > 0 && is_expired(ready_q[0].arr, ready_q[0].per)) begin
          j = ready_q[0];
          ready_q.delete(0);
          push_event(EV_MISSED, j.tid, units_left(j.ex, j.done));
        end
        if (ready_q.size() > 0) begin
          if (!run_valid) begin
            start_head();
          end else if (ready_q[0].per < running.per ||
                       (ready_q[0].per == running.per && ready_q[0].arr < running.arr)) begin
            saved = running;
            push_event(EV_PREEMPT, saved.tid, units_left(saved.ex, saved.done));
            start_head();
            enqueue(saved);
          end
        end
        if (run_valid) begin
          if (running.done != 16'hFFFF) running.done++;
          if (running.done >= running.ex) begin
            run_valid = 1'b0;
            push_event(EV_FINISHED, running.tid, '0);
          end
        end
        push_event(EV_TICK_END, run_valid ? running.tid : 8'd0,
                   run_valid ? units_left(running.ex, running.done) : 16'd0);
        if (now != '1) now++;
      end
      events_due[$].last = 1'b1;
    endfunction

    function bit check_event(input sched_event_t got, output string msg);
      sched_event_t e;
      checked++;
      if (events_due.size() == 0) begin
        msg = $sformatf("unexpected word ev=%0d task=%0d", got.ev, got.tid);
        return 1'b0;
      end
      e = events_due.pop_front();
      if (got.ev !== e.ev || got.tid !== e.tid || got.at !== e.at ||
          got.rem !== e.rem || got.busy !== e.busy || got.last !== e.last) begin
        msg = $sformatf({"got ev=%0d task=%0d t=%0d rem=%0d busy=%0b last=%0b, ",
                         "want ev=%0d task=%0d t=%0d rem=%0d busy=%0b last=%0b"},
                        got.ev, got.tid, got.at, got.rem, got.busy, got.last,
                        e.ev, e.tid, e.at, e.rem, e.busy, e.last);
        return 1'b0;
      end
      return 1'b1;
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;   // task_id, exec_time, period
  logic        in_tuser;   // opcode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;  // event_res, job_task, event_time, remaining, cpu_busy
  logic        out_tlast;

  sched_scoreboard sb;
  int errors;
  int n_arrivals;
  int n_ticks;
  int out_stall = 0;
  bit calm;

  rate_monotonic_scheduler uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    errors++;
    $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_item(input logic op, input logic [7:0] tid,
                           input logic [15:0] ex, input logic [15:0] per);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {per, ex, tid};
    do @(posedge clk); while (!in_tready);
    sb.note_item(op, tid, ex, per);
    if (op == OP_ARRIVAL) n_arrivals++;
    else n_ticks++;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic tick();
    send_item(OP_TICK, 8'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic random_arrival();
    logic [15:0] ex;
    logic [15:0] per;
    int r;
    r = $urandom_range(0, 99);
    ex = (r < 90) ? 16'($urandom_range(0, 8)) : 16'($urandom);
    r = $urandom_range(0, 99);
    if (r < 85) per = 16'($urandom_range(1, 40));
    else if (r < 90) per = '0;
    else per = 16'($urandom);
    send_item(OP_ARRIVAL, 8'($urandom), ex, per);
  endtask

  always @(posedge clk) begin
    if (out_stall > 0) begin
      out_stall <= out_stall - 1;
      out_tready <= 1'b0;
    end else begin
      out_stall <= pick_gap();
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    sched_event_t got;
    string msg;
    if (rst_n && out_tvalid && out_tready) begin
      got.ev = out_tdata[2:0];
      got.tid = out_tdata[10:3];
      got.at = out_tdata[42:11];
      got.rem = out_tdata[58:43];
      got.busy = out_tdata[59];
      got.last = out_tlast;
      if (!sb.check_event(got, msg)) report_mismatch(msg);
    end
  end

  initial begin
    #20000000;
    $display("Timeout with %0d words outstanding", sb.events_due.size());
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int r;
    sb = new();
    errors = 0;
    n_arrivals = 0;
    n_ticks = 0;
    calm = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tuser = OP_ARRIVAL;
    in_tdata = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tick();
    send_item(OP_ARRIVAL, 8'd0, 16'd0, 16'd5);
    tick();
    send_item(OP_ARRIVAL, 8'd255, 16'hFFFF, 16'hFFFF);
    tick();
    send_item(OP_ARRIVAL, 8'd7, 16'd2, 16'd3);
    tick();
    send_item(OP_ARRIVAL, 8'd9, 16'd1, 16'd0);
    tick();
    send_item(OP_ARRIVAL, 8'd10, 16'd3, 16'd3);
    send_item(OP_ARRIVAL, 8'd11, 16'd3, 16'd3);
    tick();
    tick();
    send_item(OP_ARRIVAL, 8'd12, 16'd4, 16'd1);
    tick();
    tick();
    send_item(OP_ARRIVAL, 8'd13, 16'd1, 16'd1);
    tick();
    tick();
    tick();

    for (int i = 0; i < 400; i++) begin
      calm = (i >= 150 && i < 230);
      r = $urandom_range(0, 99);
      if (r < 4) begin
        for (int k = 0; k < 18; k++) random_arrival();
        i += 17;
      end else if (r < 50) begin
        random_arrival();
      end else begin
        tick();
      end
    end
    in_tvalid <= 1'b0;

    while (sb.events_due.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    $display("Ran %0d arrivals and %0d ticks; %0d result words checked.",
             n_arrivals, n_ticks, sb.checked);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
